[rtl/tspg_pkg.sv]
// ----------------------------------------------------------------------------
// tspg_pkg
// Types and constants shared by the tile and sprite pixel generator.
// ----------------------------------------------------------------------------
package tspg_pkg;

   localparam int VADDR_W  = 16;
   localparam int OADDR_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [1:0] FUNC_VRAM_WR = 2'd0;
   localparam logic [1:0] FUNC_OAM_WR  = 2'd1;
   localparam logic [1:0] FUNC_BG_ROW  = 2'd2;
   localparam logic [1:0] FUNC_SPR_ROW = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_NAMETABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_PATTERN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SP_PATTERN = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [13:0] mem_address;
      logic [7:0] write_data;
      logic [9:0] tile_number;
      logic [5:0] sprite_number;
      logic [2:0] row_in_tile;
   } req_type;

   typedef struct packed {
      logic [8:0] pixel_x;
      logic [8:0] pixel_y;
      logic [7:0] color_index;
      logic opaque;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic vram_we;
      logic vram_re;
      logic [VADDR_W-1:0] vram_addr;
      logic [7:0] wdata;
      logic oam_we;
      logic oam_re;
      logic [OADDR_W-1:0] oam_addr;
   } mem_cmd_type;

endpackage

[rtl/tspg_mem.sv]
// ----------------------------------------------------------------------------
// tspg_mem
// Video memory and sprite attribute memory, one port each, registered reads.
// ----------------------------------------------------------------------------
module tspg_mem
   import tspg_pkg::*;
#(
   parameter int VIDEO_DEPTH = 16384,
   parameter int SPRITE_MEM_DEPTH = 256
) (
   input logic clock,
   input mem_cmd_type cmd,
   output logic [7:0] vram_rdata,
   output logic [7:0] oam_rdata
);

   localparam int VA_W = $clog2(VIDEO_DEPTH);
   localparam int SA_W = $clog2(SPRITE_MEM_DEPTH);

   logic [7:0] vram_mem [VIDEO_DEPTH];
   logic [7:0] oam_mem [SPRITE_MEM_DEPTH];
   logic [7:0] vram_rdata_ff;
   logic [7:0] oam_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.vram_we) begin
         vram_mem[cmd.vram_addr[VA_W-1:0]] <= cmd.wdata;
      end
      if (cmd.vram_re) begin
         vram_rdata_ff <= vram_mem[cmd.vram_addr[VA_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.oam_we) begin
         oam_mem[cmd.oam_addr[SA_W-1:0]] <= cmd.wdata;
      end
      if (cmd.oam_re) begin
         oam_rdata_ff <= oam_mem[cmd.oam_addr[SA_W-1:0]];
      end
   end

   assign vram_rdata = vram_rdata_ff;
   assign oam_rdata = oam_rdata_ff;

endmodule

[rtl/tile_sprite_pixel_generator_unit.sv]
// ----------------------------------------------------------------------------
// tile_sprite_pixel_generator_unit
// Renders one 8-pixel row of a background tile or a sprite, 2 bits per pixel.
// ----------------------------------------------------------------------------
// A memory write item does not raise busy. A background or sprite row item
// keeps busy high until its row is done, because every fetch goes through
// the single read port of the video memory (attribute, name, two pattern
// planes, then one palette read per pixel) or of the sprite memory. The eight
// pixels of a row come out on consecutive cycles, each for one cycle with
// rsp_strobe high; the receiver cannot stall them, so it must take every
// pixel in the cycle it is shown.
module tile_sprite_pixel_generator_unit
   import tspg_pkg::*;
#(
   parameter int VIDEO_DEPTH = 16384,
   parameter int SPRITE_MEM_DEPTH = 256,
   parameter int TILE_COUNT = 960
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input req_type req_data,
   output logic rsp_strobe,
   output rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_BG_ATTR = 4'd1;
   localparam logic [3:0] ST_BG_NAME = 4'd2;
   localparam logic [3:0] ST_SP_Y    = 4'd3;
   localparam logic [3:0] ST_SP_TILE = 4'd4;
   localparam logic [3:0] ST_SP_ATTR = 4'd5;
   localparam logic [3:0] ST_SP_X    = 4'd6;
   localparam logic [3:0] ST_PAT0    = 4'd7;
   localparam logic [3:0] ST_PAT1    = 4'd8;
   localparam logic [3:0] ST_PATW    = 4'd9;
   localparam logic [3:0] ST_PIXEL   = 4'd10;

   localparam logic [9:0] ATTR_OFFSET = 10'(TILE_COUNT);

   logic [3:0] state_ff, state_in;
   logic [1:0] nt_sel_ff;
   logic bg_sel_ff, sp_sel_ff;
   logic is_sprite_ff, is_sprite_in;
   logic [9:0] tile_ff, tile_in;
   logic [5:0] sprite_ff, sprite_in;
   logic [2:0] row_ff, row_in;
   logic [7:0] sy_ff, sy_in, stile_ff, stile_in, sattr_ff, sattr_in, sx_ff, sx_in;
   logic [1:0] pal_ff, pal_in;
   logic [13:0] pat_ff, pat_in;
   logic [7:0] p0_ff, p0_in, p1_ff, p1_in;
   logic [2:0] cnt_ff, cnt_in;
   logic pix_valid_ff, pix_valid_in;
   logic [8:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic pix_opaque_ff, pix_opaque_in, pix_last_ff, pix_last_in;

   mem_cmd_type cmd;
   logic [7:0] vram_rdata, oam_rdata;
   logic accept;
   logic [13:0] pos_addr, attr_addr, pat_addr;
   logic [1:0] attr_shift;
   logic [7:0] attr_shifted;
   logic [2:0] prow, bit_sel;
   logic [1:0] color;

   tspg_mem #(
      .VIDEO_DEPTH(VIDEO_DEPTH),
      .SPRITE_MEM_DEPTH(SPRITE_MEM_DEPTH)
   ) u_mem (
      .clock(clock),
      .cmd(cmd),
      .vram_rdata(vram_rdata),
      .oam_rdata(oam_rdata)
   );

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign csr_ready = 1'b1;

   assign pos_addr = {2'b10, nt_sel_ff, tile_ff};
   assign attr_addr = {2'b10, nt_sel_ff, ATTR_OFFSET[9:6], tile_ff[9:7], tile_ff[4:2]};
   assign attr_shift = {tile_ff[6], tile_ff[1]};
   assign attr_shifted = vram_rdata >> {attr_shift, 1'b0};
   assign prow = sattr_ff[7] ? ~row_ff : row_ff;
   assign pat_addr = is_sprite_ff ? {1'b0, sp_sel_ff, stile_ff, 1'b0, prow}
                                  : {1'b0, bg_sel_ff, vram_rdata, 1'b0, row_ff};
   assign bit_sel = (is_sprite_ff && sattr_ff[6]) ? cnt_ff : ~cnt_ff;
   assign color = {p1_ff[bit_sel], p0_ff[bit_sel]};

   always_comb begin
      state_in = state_ff;
      is_sprite_in = is_sprite_ff;
      tile_in = tile_ff;
      sprite_in = sprite_ff;
      row_in = row_ff;
      sy_in = sy_ff;
      stile_in = stile_ff;
      sattr_in = sattr_ff;
      sx_in = sx_ff;
      pal_in = pal_ff;
      pat_in = pat_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      cnt_in = cnt_ff;
      pix_valid_in = 1'b0;
      pix_x_in = pix_x_ff;
      pix_y_in = pix_y_ff;
      pix_opaque_in = pix_opaque_ff;
      pix_last_in = pix_last_ff;
      cmd = '0;
      cmd.wdata = req_data.write_data;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tile_in = req_data.tile_number;
               sprite_in = req_data.sprite_number;
               row_in = req_data.row_in_tile;
               case (req_data.func)
                  FUNC_VRAM_WR: begin
                     cmd.vram_we = 1'b1;
                     cmd.vram_addr = {2'b00, req_data.mem_address};
                  end
                  FUNC_OAM_WR: begin
                     cmd.oam_we = 1'b1;
                     cmd.oam_addr = req_data.mem_address[7:0];
                  end
                  FUNC_BG_ROW: begin
                     is_sprite_in = 1'b0;
                     sattr_in = '0;
                     state_in = ST_BG_ATTR;
                  end
                  default: begin
                     is_sprite_in = 1'b1;
                     state_in = ST_SP_Y;
                  end
               endcase
            end
         end
         ST_BG_ATTR: begin
            cmd.vram_re = 1'b1;
            cmd.vram_addr = {2'b00, attr_addr};
            state_in = ST_BG_NAME;
         end
         ST_BG_NAME: begin
            cmd.vram_re = 1'b1;
            cmd.vram_addr = {2'b00, pos_addr};
            pal_in = attr_shifted[1:0];
            state_in = ST_PAT0;
         end
         ST_SP_Y: begin
            cmd.oam_re = 1'b1;
            cmd.oam_addr = {sprite_ff, 2'd0};
            state_in = ST_SP_TILE;
         end
         ST_SP_TILE: begin
            cmd.oam_re = 1'b1;
            cmd.oam_addr = {sprite_ff, 2'd1};
            sy_in = oam_rdata;
            state_in = ST_SP_ATTR;
         end
         ST_SP_ATTR: begin
            cmd.oam_re = 1'b1;
            cmd.oam_addr = {sprite_ff, 2'd2};
            stile_in = oam_rdata;
            state_in = ST_SP_X;
         end
         ST_SP_X: begin
            cmd.oam_re = 1'b1;
            cmd.oam_addr = {sprite_ff, 2'd3};
            sattr_in = oam_rdata;
            state_in = ST_PAT0;
         end
         ST_PAT0: begin
            cmd.vram_re = 1'b1;
            cmd.vram_addr = {2'b00, pat_addr};
            pat_in = pat_addr;
            if (is_sprite_ff) begin
               sx_in = oam_rdata;
               pal_in = sattr_ff[1:0];
            end
            state_in = ST_PAT1;
         end
         ST_PAT1: begin
            cmd.vram_re = 1'b1;
            cmd.vram_addr = {2'b00, pat_ff[13:4], 1'b1, pat_ff[2:0]};
            p0_in = vram_rdata;
            state_in = ST_PATW;
         end
         ST_PATW: begin
            p1_in = vram_rdata;
            cnt_in = '0;
            state_in = ST_PIXEL;
         end
         ST_PIXEL: begin
            cmd.vram_re = 1'b1;
            cmd.vram_addr = {2'b00, 6'b111111, 3'b000, is_sprite_ff, pal_ff, color};
            pix_valid_in = 1'b1;
            pix_last_in = (cnt_ff == 3'd7);
            pix_opaque_in = !is_sprite_ff || (color != 2'd0);
            if (is_sprite_ff) begin
               pix_x_in = {1'b0, sx_ff} + {6'd0, cnt_ff};
               pix_y_in = {1'b0, sy_ff} + {6'd0, row_ff};
            end else begin
               pix_x_in = {1'b0, tile_ff[4:0], cnt_ff};
               pix_y_in = {1'b0, tile_ff[9:5], row_ff};
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pix_valid_ff <= 1'b0;
         nt_sel_ff <= '0;
         bg_sel_ff <= 1'b0;
         sp_sel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pix_valid_ff <= pix_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NAMETABLE: nt_sel_ff <= csr_data[1:0];
               CSR_BG_PATTERN: bg_sel_ff <= csr_data[0];
               CSR_SP_PATTERN: sp_sel_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      is_sprite_ff <= is_sprite_in;
      tile_ff <= tile_in;
      sprite_ff <= sprite_in;
      row_ff <= row_in;
      sy_ff <= sy_in;
      stile_ff <= stile_in;
      sattr_ff <= sattr_in;
      sx_ff <= sx_in;
      pal_ff <= pal_in;
      pat_ff <= pat_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      cnt_ff <= cnt_in;
      pix_x_ff <= pix_x_in;
      pix_y_ff <= pix_y_in;
      pix_opaque_ff <= pix_opaque_in;
      pix_last_ff <= pix_last_in;
   end

   assign rsp_strobe = pix_valid_ff;
   assign rsp_data.pixel_x = pix_x_ff;
   assign rsp_data.pixel_y = pix_y_ff;
   assign rsp_data.color_index = pix_opaque_ff ? vram_rdata : 8'd0;
   assign rsp_data.opaque = pix_opaque_ff;
   assign rsp_data.last = pix_last_ff;

endmodule

[rtl/tspg_checker.sv]
// ----------------------------------------------------------------------------
// tspg_checker
// Port-level checks on the pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
module tspg_checker
   import tspg_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input req_type req_data,
   input logic rsp_strobe,
   input rsp_type rsp_data
);

   logic accept;
   logic is_write;

   assign accept = start && !busy;
   assign is_write = (req_data.func == FUNC_VRAM_WR) || (req_data.func == FUNC_OAM_WR);

   // A memory write item gives no pixel.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      accept && is_write |=> !rsp_strobe)
      else $error("pixel strobe after a write item");

   // A row item keeps the block busy on the next cycle.
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      accept && !is_write |=> busy)
      else $error("row item did not make the block busy");

   // The eight pixels of a row come on consecutive cycles.
   a_row_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("gap inside a pixel row");

   // Nothing follows the last pixel directly.
   a_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |=> !rsp_strobe)
      else $error("pixel directly after the last pixel of a row");

   // A transparent pixel carries color index zero.
   a_transparent: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.opaque |-> rsp_data.color_index == 8'd0)
      else $error("transparent pixel with nonzero color index");

endmodule

bind tile_sprite_pixel_generator_unit tspg_checker u_tspg_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_data(req_data),
   .rsp_strobe(rsp_strobe),
   .rsp_data(rsp_data)
);

[tb/sv/tb_tile_sprite_pixel_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_sprite_pixel_generator_unit
// Self-checking bench for the tile and sprite row renderer. Write items load
// the video and sprite memories, and row items are rendered by a local
// predictor into expected pixels. Every pixel on the strobe is checked against
// them in order. Before each row item is queued, the bench loads every memory
// byte that the row will read and that has not been written yet, so that no
// unwritten entry is ever fetched. Several register settings are covered, and
// the sender idles at three different rates.
// ----------------------------------------------------------------------------
module tb_tile_sprite_pixel_generator_unit;
   import tspg_pkg::*;

   localparam int VRAM_BYTES        = 16384;
   localparam int OAM_BYTES         = 256;
   localparam int TILES_ON_SCREEN   = 960;
   localparam int NAME_TABLE_BASE   = 'h2000;
   localparam int NAME_TABLE_STRIDE = 'h0400;
   localparam int PATTERN_UPPER     = 'h1000;
   localparam int BG_PALETTE        = 'h3F00;
   localparam int SPRITE_PALETTE    = 'h3F10;
   localparam int CYCLE_LIMIT       = 200000;
   localparam int SETTLE_CYCLES     = 24;
   localparam int SEGMENT_ITEMS     = 88;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   req_type pending_items[$];
   rsp_type expected_pixels[$];
   int items_queued = 0;
   int mismatches = 0;
   int gap_pct = 0;
   int cycle_count = 0;
   bit item_taken = 1'b0;

   logic [1:0] cfg_nametable = '0;
   logic cfg_bg_pattern = 1'b0;
   logic cfg_sp_pattern = 1'b0;

   logic [7:0] pix_vram [VRAM_BYTES];
   logic [7:0] pix_oam [OAM_BYTES];
   logic [7:0] plan_vram [VRAM_BYTES];
   logic [7:0] plan_oam [OAM_BYTES];
   bit plan_vram_set [VRAM_BYTES];
   bit plan_oam_set [OAM_BYTES];

   tile_sprite_pixel_generator_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic req_type random_req();
      req_type it;
      it.func = 2'($urandom);
      it.mem_address = 14'($urandom);
      it.write_data = 8'($urandom);
      it.tile_number = 10'($urandom);
      it.sprite_number = 6'($urandom);
      it.row_in_tile = 3'($urandom);
      return it;
   endfunction

   function automatic void queue_item(req_type it);
      pending_items.push_back(it);
      items_queued++;
   endfunction

   function automatic void queue_vram_write(int addr, logic [7:0] value);
      req_type it;
      it = random_req();
      it.func = FUNC_VRAM_WR;
      it.mem_address = 14'(addr);
      it.write_data = value;
      plan_vram[addr % VRAM_BYTES] = value;
      plan_vram_set[addr % VRAM_BYTES] = 1'b1;
      queue_item(it);
   endfunction

   function automatic void queue_oam_write(int addr, logic [7:0] value);
      req_type it;
      it = random_req();
      it.func = FUNC_OAM_WR;
      it.mem_address = {6'($urandom), 8'(addr)};
      it.write_data = value;
      plan_oam[addr % OAM_BYTES] = value;
      plan_oam_set[addr % OAM_BYTES] = 1'b1;
      queue_item(it);
   endfunction

   function automatic logic [7:0] vram_fetch(int addr, bit planning);
      int a;
      a = addr % VRAM_BYTES;
      if (planning) begin
         if (!plan_vram_set[a]) queue_vram_write(a, random_byte());
         return plan_vram[a];
      end
      return pix_vram[a];
   endfunction

   function automatic logic [7:0] oam_fetch(int addr, bit planning);
      int a;
      a = addr % OAM_BYTES;
      if (planning) begin
         if (!plan_oam_set[a]) queue_oam_write(a, random_byte());
         return plan_oam[a];
      end
      return pix_oam[a];
   endfunction

   // With planning set, the row is walked against the planned memory image and
   // missing bytes are loaded; otherwise its pixels become expectations.
   function automatic void render_row(req_type it, bit planning);
      int nt, pos, attr_addr, shift, pal, name, pat, tile, row;
      int sx, sy, stile, prow, b, c, i;
      logic [7:0] attr, p0, p1;
      rsp_type px;
      row = it.row_in_tile;
      if (it.func == FUNC_BG_ROW) begin
         tile = it.tile_number;
         nt = NAME_TABLE_BASE + NAME_TABLE_STRIDE * cfg_nametable;
         pos = nt + tile;
         attr_addr = (nt + TILES_ON_SCREEN) | (pos & 'hC00) | ((pos >> 4) & 'h38) |
                     ((pos >> 2) & 'h07);
         attr = vram_fetch(attr_addr, planning);
         shift = ((pos & 'h40) >> 4) | (pos & 'h2);
         pal = (attr >> shift) & 3;
         name = vram_fetch(pos, planning);
         pat = (cfg_bg_pattern ? PATTERN_UPPER : 0) + name * 16 + row;
         p0 = vram_fetch(pat, planning);
         p1 = vram_fetch(pat + 8, planning);
         for (i = 0; i < 8; i++) begin
            b = 7 - i;
            c = {p1[b], p0[b]};
            px.pixel_x = 9'((tile % 32) * 8 + i);
            px.pixel_y = 9'((tile / 32) * 8 + row);
            px.color_index = vram_fetch(BG_PALETTE + 4 * pal + c, planning);
            px.opaque = 1'b1;
            px.last = (i == 7);
            if (!planning) expected_pixels.push_back(px);
         end
      end else begin
         sy = oam_fetch(it.sprite_number * 4, planning);
         stile = oam_fetch(it.sprite_number * 4 + 1, planning);
         attr = oam_fetch(it.sprite_number * 4 + 2, planning);
         sx = oam_fetch(it.sprite_number * 4 + 3, planning);
         prow = attr[7] ? 7 - row : row;
         pat = (cfg_sp_pattern ? PATTERN_UPPER : 0) + stile * 16 + prow;
         p0 = vram_fetch(pat, planning);
         p1 = vram_fetch(pat + 8, planning);
         pal = attr & 3;
         if (planning) void'(vram_fetch(SPRITE_PALETTE + 4 * pal, planning));
         for (i = 0; i < 8; i++) begin
            b = attr[6] ? i : 7 - i;
            c = {p1[b], p0[b]};
            px.pixel_x = 9'(sx + i);
            px.pixel_y = 9'(sy + row);
            px.color_index = 8'h00;
            if (c != 0) px.color_index = vram_fetch(SPRITE_PALETTE + 4 * pal + c, planning);
            px.opaque = (c != 0);
            px.last = (i == 7);
            if (!planning) expected_pixels.push_back(px);
         end
      end
   endfunction

   function automatic void queue_row(logic [1:0] func, int tile, int sprite, int row);
      req_type it;
      it = random_req();
      it.func = func;
      it.tile_number = 10'(tile);
      it.sprite_number = 6'(sprite);
      it.row_in_tile = 3'(row);
      render_row(it, 1'b1);
      queue_item(it);
   endfunction

   function automatic void load_sprite_row(int num, int y, int tile, int attr, int x,
                                           int row);
      queue_oam_write(num * 4, 8'(y));
      queue_oam_write(num * 4 + 1, 8'(tile));
      queue_oam_write(num * 4 + 2, 8'(attr));
      queue_oam_write(num * 4 + 3, 8'(x));
      queue_row(FUNC_SPR_ROW, $urandom_range(1023), num, row);
   endfunction

   function automatic void apply_item(req_type it);
      case (it.func)
         FUNC_VRAM_WR: pix_vram[it.mem_address] = it.write_data;
         FUNC_OAM_WR: pix_oam[it.mem_address[7:0]] = it.write_data;
         default: render_row(it, 1'b0);
      endcase
   endfunction

   function automatic void check_pixel(rsp_type got);
      rsp_type want;
      if (expected_pixels.size() == 0) begin
         $error("unexpected pixel at x %0d y %0d", got.pixel_x, got.pixel_y);
         mismatches++;
      end else begin
         want = expected_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x) begin
            $error("pixel_x expected %0d actual %0d", want.pixel_x, got.pixel_x);
            mismatches++;
         end
         if (got.pixel_y !== want.pixel_y) begin
            $error("pixel_y expected %0d actual %0d", want.pixel_y, got.pixel_y);
            mismatches++;
         end
         if (got.color_index !== want.color_index) begin
            $error("color_index expected %0d actual %0d", want.color_index, got.color_index);
            mismatches++;
         end
         if (got.opaque !== want.opaque) begin
            $error("opaque expected %0d actual %0d", want.opaque, got.opaque);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, got.last);
            mismatches++;
         end
      end
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
            start <= 1'b1;
            req_data <= pending_items.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
      item_taken = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) check_pixel(rsp_data);
         if (start && busy === 1'b0) begin
            item_taken = 1'b1;
            apply_item(req_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tile_sprite_pixel_generator_unit regression: fail");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || start || busy !== 1'b0 ||
             expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value, int value_bits);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(($urandom << value_bits) | value);
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         CSR_NAMETABLE: cfg_nametable = csr_data[1:0];
         CSR_BG_PATTERN: cfg_bg_pattern = csr_data[0];
         CSR_SP_PATTERN: cfg_sp_pattern = csr_data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(int nt, int bgp, int spp);
      wait_idle();
      write_csr(CSR_NAMETABLE, nt, 2);
      write_csr(CSR_BG_PATTERN, bgp, 1);
      write_csr(CSR_SP_PATTERN, spp, 1);
   endtask

   task automatic run_segment(int gap, int nt, int bgp, int spp);
      int r, target, tile;
      set_config(nt, bgp, spp);
      gap_pct = gap;
      target = items_queued + SEGMENT_ITEMS;
      while (items_queued < target) begin
         r = $urandom_range(99);
         if (r < 35) begin
            tile = $urandom_range(1023);
            if ($urandom_range(3) == 0)
               queue_vram_write(NAME_TABLE_BASE + NAME_TABLE_STRIDE * cfg_nametable + tile,
                                random_byte());
            queue_row(FUNC_BG_ROW, tile, $urandom_range(63), $urandom_range(7));
         end else if (r < 70) begin
            if ($urandom_range(1) == 0)
               load_sprite_row($urandom_range(63), $urandom_range(255), $urandom_range(255),
                               $urandom_range(255), $urandom_range(255), $urandom_range(7));
            else
               queue_row(FUNC_SPR_ROW, $urandom_range(1023), $urandom_range(63),
                         $urandom_range(7));
         end else if (r < 85) begin
            queue_vram_write($urandom_range(VRAM_BYTES - 1), random_byte());
         end else begin
            queue_oam_write($urandom_range(OAM_BYTES - 1), random_byte());
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      gap_pct = 10;
      set_config(0, 0, 0);

      queue_vram_write(0, 8'h00);
      queue_vram_write(VRAM_BYTES - 1, 8'hFF);
      queue_oam_write(OAM_BYTES - 1, 8'hFF);
      queue_row(FUNC_BG_ROW, 0, 0, 0);
      queue_row(FUNC_BG_ROW, TILES_ON_SCREEN - 1, 63, 7);
      queue_row(FUNC_BG_ROW, TILES_ON_SCREEN, 0, 3);
      queue_row(FUNC_BG_ROW, 1023, 63, 7);
      queue_row(FUNC_BG_ROW, 33, 5, 4);
      // Sprite tile 5, pattern row 2, has transparent pixels in its second and fourth columns.
      queue_vram_write(5 * 16 + 2, 8'hA5);
      queue_vram_write(5 * 16 + 10, 8'h0F);
      load_sprite_row(0, 0, 5, 'h00, 0, 2);
      load_sprite_row(1, 40, 5, 'h41, 100, 2);
      load_sprite_row(2, 80, 5, 'h82, 50, 5);
      load_sprite_row(63, 255, 5, 'hC3, 255, 7);

      run_segment(10, 3, 1, 1);
      run_segment(65, 1, 0, 1);
      run_segment(0, 2, 1, 0);
      run_segment(0, 0, 0, 1);
      wait_idle();
      if (mismatches == 0)
         $display("tile_sprite_pixel_generator_unit regression: pass");
      else
         $display("tile_sprite_pixel_generator_unit regression: fail");
      $finish;
   end

endmodule
